// ----- src/yp2r_pkg.sv -----
package yp2r_pkg;

  // Default fraction width of the fixed-point coefficients
  localparam int COEF_FRAC_BITS_DEF = 10;

  // Coefficients in thousandths
  localparam int MILLI_Y  = 1164;
  localparam int MILLI_BU = 2018;
  localparam int MILLI_GV = 813;
  localparam int MILLI_GU = 394;
  localparam int MILLI_RV = 1596;

  localparam int LUMA_OFS = 16;
  localparam int KNEE     = 250;
  localparam int SAT      = 255;

  localparam int NUM_STAGES = 4;

  // Per-stage load enables handed from the control to the datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stg_en_t;

endpackage

// ----- src/yp2r_if.sv -----
interface yp2r_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] chroma_blue;
  logic [7:0] luma_second;
  logic [7:0] chroma_red;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  input ready);
  modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                output ready);
endinterface

interface yp2r_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_first;
  logic [7:0] green_first;
  logic [7:0] blue_first;
  logic [7:0] red_second;
  logic [7:0] green_second;
  logic [7:0] blue_second;

  modport source (output valid, red_first, green_first, blue_first,
                  red_second, green_second, blue_second, input ready);
  modport sink (input valid, red_first, green_first, blue_first,
                red_second, green_second, blue_second, output ready);
endinterface

// ----- src/yp2r_dp.sv -----
module yp2r_dp #(
  parameter int CoefFracBits = yp2r_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  yp2r_pkg::stg_en_t   en,
  input  logic [7:0]          luma_first,
  input  logic [7:0]          chroma_blue,
  input  logic [7:0]          luma_second,
  input  logic [7:0]          chroma_red,
  output logic [7:0]          red_first,
  output logic [7:0]          green_first,
  output logic [7:0]          blue_first,
  output logic [7:0]          red_second,
  output logic [7:0]          green_second,
  output logic [7:0]          blue_second
);

  localparam int CW = CoefFracBits + 3;   // signed coefficient width
  localparam int PW = CW + 9;             // signed product width
  localparam int SW = PW + 2;             // signed sum width

  localparam int CoefYInt  = (yp2r_pkg::MILLI_Y  * (1 << CoefFracBits) + 500) / 1000;
  localparam int CoefBuInt = (yp2r_pkg::MILLI_BU * (1 << CoefFracBits) + 500) / 1000;
  localparam int CoefGvInt = (yp2r_pkg::MILLI_GV * (1 << CoefFracBits) + 500) / 1000;
  localparam int CoefGuInt = (yp2r_pkg::MILLI_GU * (1 << CoefFracBits) + 500) / 1000;
  localparam int CoefRvInt = (yp2r_pkg::MILLI_RV * (1 << CoefFracBits) + 500) / 1000;
  localparam int KneeInt   = yp2r_pkg::KNEE * (1 << CoefFracBits);

  localparam logic signed [CW-1:0] CoefY  = CW'(CoefYInt);
  localparam logic signed [CW-1:0] CoefBu = CW'(CoefBuInt);
  localparam logic signed [CW-1:0] CoefGv = CW'(CoefGvInt);
  localparam logic signed [CW-1:0] CoefGu = CW'(CoefGuInt);
  localparam logic signed [CW-1:0] CoefRv = CW'(CoefRvInt);
  localparam logic signed [SW-1:0] KneeFix = SW'(KneeInt);
  localparam logic [7:0] SatVal = 8'(yp2r_pkg::SAT);

  // Stage 1: remove offsets
  logic signed [8:0] y0_r, y1_r;
  logic signed [7:0] u_r, v_r;
  logic signed [8:0] y0_nxt, y1_nxt;
  logic signed [7:0] u_nxt, v_nxt;

  // Stage 2: products
  logic signed [PW-1:0] yt0_r, yt1_r, rv_r, gv_r, gu_r, bu_r;
  logic signed [PW-1:0] yt0_nxt, yt1_nxt, rv_nxt, gv_nxt, gu_nxt, bu_nxt;

  // Stage 3: channel sums
  logic signed [SW-1:0] r0_r, g0_r, b0_r, r1_r, g1_r, b1_r;
  logic signed [SW-1:0] r0_nxt, g0_nxt, b0_nxt, r1_nxt, g1_nxt, b1_nxt;

  // Stage 4: clamped output register
  logic [7:0] ro0_r, go0_r, bo0_r, ro1_r, go1_r, bo1_r;

  function automatic logic [7:0] clamp_ch(input logic signed [SW-1:0] sum);
    logic [7:0] res;
    priority if (sum > KneeFix) res = SatVal;
    else if (sum[SW-1])         res = 8'd0;
    else                        res = sum[CoefFracBits +: 8];
    return res;
  endfunction

  always_comb begin
    y0_nxt = $signed({1'b0, luma_first}) - 9'(yp2r_pkg::LUMA_OFS);
    y1_nxt = $signed({1'b0, luma_second}) - 9'(yp2r_pkg::LUMA_OFS);
    // flipping the top bit subtracts 128 in two's complement
    u_nxt  = $signed({~chroma_blue[7], chroma_blue[6:0]});
    v_nxt  = $signed({~chroma_red[7], chroma_red[6:0]});
  end

  always_comb begin
    yt0_nxt = PW'(y0_r) * PW'(CoefY);
    yt1_nxt = PW'(y1_r) * PW'(CoefY);
    rv_nxt  = PW'(v_r) * PW'(CoefRv);
    gv_nxt  = PW'(v_r) * PW'(CoefGv);
    gu_nxt  = PW'(u_r) * PW'(CoefGu);
    bu_nxt  = PW'(u_r) * PW'(CoefBu);
  end

  always_comb begin
    r0_nxt = SW'(yt0_r) + SW'(rv_r);
    g0_nxt = SW'(yt0_r) - SW'(gv_r) - SW'(gu_r);
    b0_nxt = SW'(yt0_r) + SW'(bu_r);
    r1_nxt = SW'(yt1_r) + SW'(rv_r);
    g1_nxt = SW'(yt1_r) - SW'(gv_r) - SW'(gu_r);
    b1_nxt = SW'(yt1_r) + SW'(bu_r);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y0_r <= y0_nxt;
      y1_r <= y1_nxt;
      u_r  <= u_nxt;
      v_r  <= v_nxt;
    end
    if (en.s2) begin
      yt0_r <= yt0_nxt;
      yt1_r <= yt1_nxt;
      rv_r  <= rv_nxt;
      gv_r  <= gv_nxt;
      gu_r  <= gu_nxt;
      bu_r  <= bu_nxt;
    end
    if (en.s3) begin
      r0_r <= r0_nxt;
      g0_r <= g0_nxt;
      b0_r <= b0_nxt;
      r1_r <= r1_nxt;
      g1_r <= g1_nxt;
      b1_r <= b1_nxt;
    end
    if (en.s4) begin
      ro0_r <= clamp_ch(r0_r);
      go0_r <= clamp_ch(g0_r);
      bo0_r <= clamp_ch(b0_r);
      ro1_r <= clamp_ch(r1_r);
      go1_r <= clamp_ch(g1_r);
      bo1_r <= clamp_ch(b1_r);
    end
  end

  assign red_first    = ro0_r;
  assign green_first  = go0_r;
  assign blue_first   = bo0_r;
  assign red_second   = ro1_r;
  assign green_second = go1_r;
  assign blue_second  = bo1_r;

endmodule

// ----- src/yuyv_pair_to_rgb_unit.sv -----
// Channel   Direction  Handshake          Payload
// in_ch     sink       valid / ready      luma_first, chroma_blue, luma_second, chroma_red
// out_ch    source     valid / ready      red/green/blue of first and second pixel
//
// One transaction per cycle sustained while out_ch.ready stays high; four register
// stages (offset, multiply, sum, clamp), which an accepted transaction passes
// through in that order before its result shows on out_ch.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// Each stage holds while its successor is full and stalled; a bubble in the
// pipe is filled even while the output waits, so in_ch.ready drops only when
// all four stages hold data and out_ch.ready is low.
module yuyv_pair_to_rgb_unit #(
  parameter int CoefFracBits = yp2r_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  yp2r_in_if.sink      in_ch,
  yp2r_out_if.source   out_ch
);

  localparam int NS = yp2r_pkg::NUM_STAGES;

  logic [NS-1:0] vld_r, vld_nxt;
  logic [NS:0]   rdy;
  logic [NS:0]   vin;
  yp2r_pkg::stg_en_t en;

  always_comb begin
    rdy[NS] = out_ch.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vin = {vld_r, in_ch.valid};
    for (int k = 0; k < NS; k++) begin
      vld_nxt[k] = rdy[k] ? vin[k] : vld_r[k];
    end
  end

  assign en.s1 = rdy[0];
  assign en.s2 = rdy[1];
  assign en.s3 = rdy[2];
  assign en.s4 = rdy[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = vld_r[NS-1];

  yp2r_dp #(
    .CoefFracBits (CoefFracBits)
  ) u_dp (
    .clk          (clk),
    .en           (en),
    .luma_first   (in_ch.luma_first),
    .chroma_blue  (in_ch.chroma_blue),
    .luma_second  (in_ch.luma_second),
    .chroma_red   (in_ch.chroma_red),
    .red_first    (out_ch.red_first),
    .green_first  (out_ch.green_first),
    .blue_first   (out_ch.blue_first),
    .red_second   (out_ch.red_second),
    .green_second (out_ch.green_second),
    .blue_second  (out_ch.blue_second)
  );

  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted transaction did not reach the first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&vld_r) && !out_ch.ready)
    else $error("input stalled with a bubble in the pipe");

  a_s3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] && en.s4 |=> out_ch.valid)
    else $error("sum stage advanced without producing a result");

endmodule
